[rtl/lpht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, codes and the key mixing functions of the probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_VALUE_BITS = 32;
    localparam int KEY_BITS       = 64;
    localparam int CMD_BITS       = 2;
    localparam int VALUE_FIELD    = 32;
    localparam int SLOT_FIELD     = 10;
    localparam int STATUS_BITS    = 2;
    localparam logic [63:0] MIX_MUL = 64'hff51afd7ed558ccd;
    localparam int MIX_SHIFT      = 33;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_OTHER  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZEROKEY  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_SHIFT_RD,
        S_SHIFT_HASH,
        S_SHIFT_CHK,
        S_EMIT,
        S_WAIT
    } fsm_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic hash_key;
        logic probe_rd;
        logic probe_next;
        logic insert_wr;
        logic erase_start;
        logic shift_rd;
        logic shift_hash;
        logic shift_move;
        logic shift_next;
        logic gap_clear;
        logic set_result;
        logic [1:0] result_kind;
    } ctrl_t;

    localparam logic [1:0] R_HIT     = 2'd0;
    localparam logic [1:0] R_INSERT  = 2'd1;
    localparam logic [1:0] R_MISS    = 2'd2;
    localparam logic [1:0] R_SPECIAL = 2'd3;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic key_zero;
        logic is_insert;
        logic is_erase;
        logic full;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic shift_empty;
        logic shift_last;
        logic shift_move_ok;
    } stat_t;

    function automatic logic [63:0] mix_pre(input logic [63:0] k);
        mix_pre = k ^ (k >> MIX_SHIFT);
    endfunction

    function automatic logic [63:0] mix_post(input logic [63:0] h);
        mix_post = h ^ (h >> MIX_SHIFT);
    endfunction

endpackage

[rtl/lpht_mix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_mix
// Key mixer: the 64-bit multiply is split into three 32x32 partial
// products registered before being summed.
// ----------------------------------------------------------------------------
module lpht_mix #(
    parameter int SLOT_W = 10
) (
    input  logic              aclk,
    input  logic [63:0]       key,
    output logic [SLOT_W-1:0] home
);
    import lpht_pkg::*;

    logic [63:0] pre;
    logic [63:0] ll_reg, lh_reg, hl_reg;
    logic [63:0] prod;

    assign pre = mix_pre(key);

    always_ff @(posedge aclk) begin
        ll_reg <= 64'(pre[31:0]) * 64'(MIX_MUL[31:0]);
        lh_reg <= 64'(pre[31:0]) * 64'(MIX_MUL[63:32]);
        hl_reg <= 64'(pre[63:32]) * 64'(MIX_MUL[31:0]);
    end

    assign prod = ll_reg + {lh_reg[31:0] + hl_reg[31:0], 32'd0};
    assign home = SLOT_W'(mix_post(prod));
endmodule

[rtl/lpht_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_datapath
// Key and value memories, probe and gap pointers, occupancy count and the
// result register.
// ----------------------------------------------------------------------------
module lpht_datapath #(
    parameter int SLOTS      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           in_cmd,
    input  logic [63:0]          in_key,
    input  logic [31:0]          in_value,
    input  lpht_pkg::ctrl_t      ctrl,
    output lpht_pkg::stat_t      stat,
    output logic [44:0]          result
);
    import lpht_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int LIM_W  = SLOT_W + 4;
    localparam logic [LIM_W-1:0] LIMIT = LIM_W'(3 * SLOTS);

    logic [63:0]           keys_mem [SLOTS];
    logic [VALUE_BITS-1:0] vals_mem [SLOTS];

    logic [1:0]            cmd_reg;
    logic [63:0]           key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [SLOT_W-1:0]     idx_reg, gap_reg, home_reg;
    logic [CNT_W-1:0]      n_reg, cnt_reg, clr_reg;
    logic [63:0]           rkey_reg;
    logic [VALUE_BITS-1:0] rval_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic [SLOT_W-1:0]     hit_slot_reg;
    logic [44:0]           result_reg;
    logic [63:0]           mix_key;
    logic [SLOT_W-1:0]     home;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     d_gap, d_j;
    logic [SLOT_W-1:0]     idx_inc;
    logic [31:0]           vout;

    assign mix_key = ctrl.shift_hash ? rkey_reg : key_reg;

    lpht_mix #(.SLOT_W(SLOT_W)) u_mix (
        .aclk (aclk),
        .key  (mix_key),
        .home (home)
    );

    assign idx_inc = idx_reg + SLOT_W'(1);
    assign rd_addr = idx_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.probe_rd || ctrl.shift_rd) begin
            rkey_reg <= keys_mem[rd_addr];
            rval_reg <= vals_mem[rd_addr];
        end
        if (ctrl.clear_wr) begin
            keys_mem[clr_reg[SLOT_W-1:0]] <= '0;
        end else if (ctrl.insert_wr) begin
            keys_mem[idx_reg] <= key_reg;
            vals_mem[idx_reg] <= val_reg;
        end else if (ctrl.shift_move) begin
            keys_mem[gap_reg] <= rkey_reg;
            vals_mem[gap_reg] <= rval_reg;
        end else if (ctrl.gap_clear) begin
            keys_mem[gap_reg] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (ctrl.clear_wr) begin
                clr_reg <= clr_reg + CNT_W'(1);
            end
            if (ctrl.insert_wr) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (ctrl.erase_start && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
            val_reg <= VALUE_BITS'(in_value);
        end
        if (ctrl.hash_key) begin
            idx_reg <= home;
            n_reg   <= '0;
        end else if (ctrl.probe_next) begin
            idx_reg <= idx_inc;
            n_reg   <= n_reg + CNT_W'(1);
        end else if (ctrl.erase_start) begin
            hit_val_reg  <= rval_reg;
            hit_slot_reg <= idx_reg;
            gap_reg      <= idx_reg;
            idx_reg      <= idx_inc;
            n_reg        <= '0;
        end else if (ctrl.shift_next) begin
            idx_reg <= idx_inc;
            n_reg   <= n_reg + CNT_W'(1);
        end
        if (ctrl.shift_hash) begin
            home_reg <= home;
        end
        if (ctrl.shift_move) begin
            gap_reg <= idx_reg;
        end
        if (ctrl.probe_rd && !ctrl.erase_start) begin
            hit_val_reg  <= vals_mem[rd_addr];
            hit_slot_reg <= rd_addr;
        end
    end

    assign d_gap = gap_reg - home_reg;
    assign d_j   = idx_reg - home_reg;

    always_comb begin
        vout = '0;
        unique case (ctrl.result_kind)
            R_HIT:     vout = 32'(rval_reg);
            R_INSERT:  vout = 32'(val_reg);
            R_MISS:    vout = '0;
            R_SPECIAL: vout = '0;
            default:   vout = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.set_result) begin
            unique case (ctrl.result_kind)
                R_HIT: begin
                    result_reg <= {ST_OK, 10'(idx_reg), vout, 1'b1};
                end
                R_INSERT: begin
                    result_reg <= {ST_OK, 10'(idx_reg), vout, 1'b0};
                end
                R_MISS: begin
                    result_reg <= {ST_NOTFOUND, 10'd0, 32'd0, 1'b0};
                end
                R_SPECIAL: begin
                    result_reg <= {(key_reg == '0) ? ST_ZEROKEY : ST_FULL,
                                   10'd0, 32'd0, 1'b0};
                end
                default: result_reg <= '0;
            endcase
        end else if (ctrl.gap_clear) begin
            result_reg <= {ST_OK, 10'(hit_slot_reg), 32'(hit_val_reg), 1'b1};
        end
    end

    assign result = result_reg;

    assign stat.clear_done    = (clr_reg == CNT_W'(SLOTS));
    assign stat.key_zero      = (key_reg == '0);
    assign stat.is_insert     = (cmd_reg == CMD_INSERT);
    assign stat.is_erase      = (cmd_reg == CMD_ERASE);
    assign stat.full          = ({3'd0, cnt_reg} + LIM_W'(1)) * LIM_W'(4) >= LIMIT;
    assign stat.slot_empty    = (rkey_reg == '0);
    assign stat.slot_match    = (rkey_reg == key_reg);
    assign stat.probe_last    = (n_reg == CNT_W'(SLOTS - 1));
    assign stat.shift_empty   = (rkey_reg == '0);
    assign stat.shift_last    = (n_reg == CNT_W'(SLOTS - 1));
    assign stat.shift_move_ok = (d_gap < d_j);
endmodule

[rtl/lpht_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer for the clearing pass, probe runs, insert and backward shift.
// ----------------------------------------------------------------------------
module lpht_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  lpht_pkg::stat_t stat,
    output lpht_pkg::ctrl_t ctrl
);
    import lpht_pkg::*;

    fsm_t state_reg, state_next;
    logic seek_reg, seek_next;
    logic [1:0] wait_reg, wait_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            seek_reg  <= 1'b0;
            wait_reg  <= '0;
        end else begin
            state_reg <= state_next;
            seek_reg  <= seek_next;
            wait_reg  <= wait_next;
        end
    end

    // seek_reg marks the insert pass that looks for a free slot.
    always_comb begin
        state_next = state_reg;
        seek_next  = seek_reg;
        wait_next  = wait_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end else begin
                    ctrl.clear_wr = 1'b1;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctrl.load  = 1'b1;
                    seek_next  = 1'b0;
                    wait_next  = '0;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (stat.key_zero) begin
                    ctrl.set_result  = 1'b1;
                    ctrl.result_kind = R_SPECIAL;
                    state_next       = S_EMIT;
                end else if (wait_reg == 2'd1) begin
                    ctrl.hash_key = 1'b1;
                    state_next    = S_PROBE_RD;
                end else begin
                    wait_next = wait_reg + 2'd1;
                end
            end
            S_PROBE_RD: begin
                ctrl.probe_rd = 1'b1;
                state_next    = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (seek_reg) begin
                    if (stat.slot_empty) begin
                        ctrl.insert_wr   = 1'b1;
                        ctrl.set_result  = 1'b1;
                        ctrl.result_kind = R_INSERT;
                        state_next       = S_EMIT;
                    end else if (stat.probe_last) begin
                        ctrl.set_result  = 1'b1;
                        ctrl.result_kind = R_SPECIAL;
                        state_next       = S_EMIT;
                    end else begin
                        ctrl.probe_next = 1'b1;
                        state_next      = S_PROBE_RD;
                    end
                end else if (!stat.slot_empty && stat.slot_match) begin
                    if (stat.is_erase) begin
                        ctrl.erase_start = 1'b1;
                        state_next       = S_SHIFT_RD;
                    end else begin
                        ctrl.set_result  = 1'b1;
                        ctrl.result_kind = R_HIT;
                        state_next       = S_EMIT;
                    end
                end else if (stat.slot_empty || stat.probe_last) begin
                    if (stat.is_insert) begin
                        if (stat.full) begin
                            ctrl.set_result  = 1'b1;
                            ctrl.result_kind = R_SPECIAL;
                            state_next       = S_EMIT;
                        end else begin
                            seek_next     = 1'b1;
                            ctrl.hash_key = 1'b1;
                            state_next    = S_PROBE_RD;
                        end
                    end else begin
                        ctrl.set_result  = 1'b1;
                        ctrl.result_kind = R_MISS;
                        state_next       = S_EMIT;
                    end
                end else begin
                    ctrl.probe_next = 1'b1;
                    state_next      = S_PROBE_RD;
                end
            end
            S_SHIFT_RD: begin
                ctrl.shift_rd = 1'b1;
                wait_next     = '0;
                state_next    = S_SHIFT_HASH;
            end
            S_SHIFT_HASH: begin
                if (stat.shift_empty) begin
                    ctrl.gap_clear = 1'b1;
                    state_next     = S_EMIT;
                end else if (wait_reg == 2'd1) begin
                    ctrl.shift_hash = 1'b1;
                    state_next      = S_SHIFT_CHK;
                end else begin
                    ctrl.shift_hash = 1'b1;
                    wait_next       = wait_reg + 2'd1;
                end
            end
            S_SHIFT_CHK: begin
                ctrl.shift_move = stat.shift_move_ok;
                if (stat.shift_last) begin
                    state_next = S_WAIT;
                end else begin
                    ctrl.shift_next = 1'b1;
                    state_next      = S_SHIFT_RD;
                end
            end
            S_WAIT: begin
                ctrl.gap_clear = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

[rtl/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key to value table with linear probing and backward-shift
// deletion.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// s_axis   in   command, key_id, entry_value
// m_axis   out  found, value_out, slot_out, status
//
// A request probes slot by slot from the key's home slot; a zero key is
// refused without probing. An insert of a new key probes its cluster twice;
// an erase then walks the following cluster and shifts its entries back.
// After reset a clearing pass empties the key store.
// One request is held at a time; a stalled result holds in its register.
module linear_probe_hash_table #(
    parameter int SLOTS      = lpht_pkg::DEF_SLOTS,
    parameter int VALUE_BITS = lpht_pkg::DEF_VALUE_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // command[1:0], key_id[65:2], entry_value[97:66]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata   // found[0], value_out[32:1], slot_out[42:33],
                                        // status[44:43]
);
    import lpht_pkg::*;

    ctrl_t       ctrl;
    stat_t       stat;
    logic [44:0] result;

    lpht_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lpht_datapath #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_cmd   (s_axis_tdata[1:0]),
        .in_key   (s_axis_tdata[65:2]),
        .in_value (s_axis_tdata[97:66]),
        .ctrl     (ctrl),
        .stat     (stat),
        .result   (result)
    );

    assign m_axis_tdata = {3'd0, result};
endmodule

[rtl/lpht_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [103:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata
);
    import lpht_pkg::*;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted while a result waits");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[44:43] != ST_OK |-> m_axis_tdata[42:0] == '0)
        else $error("failed request carries data");

    a_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[65:2] == '0
        |-> ##2 m_axis_tvalid && m_axis_tdata[44:43] == ST_ZEROKEY)
        else $error("zero key not refused");
endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives lookup, insert, erase and CMD_OTHER requests into the probing hash
// table and checks every answer against a behavioural copy of the table kept here.
// ----------------------------------------------------------------------------
module tb_top;
    import lpht_pkg::*;

    localparam int NSLOTS = 1024;
    localparam int LOAD_LIMIT = NSLOTS * 3;

    typedef struct packed {
        logic [31:0] val;
        logic [63:0] key;
        logic [1:0]  cmd;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot;
        logic [31:0] value;
        logic        found;
    } answer_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    logic [63:0] keys_held[$];
    logic [63:0] tbl_keys[NSLOTS];
    logic [31:0] tbl_vals[NSLOTS];
    int  tbl_count;
    int  errors = 0;
    bit  stimulus_done = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  rx_phase = 0;

    linear_probe_hash_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic logic [9:0] home_slot(input logic [63:0] k);
        logic [63:0] h;
        h = k ^ (k >> 33);
        h = h * 64'hff51afd7ed558ccd;
        h = h ^ (h >> 33);
        return h[9:0];
    endfunction

    function automatic void erase_slot(input logic [9:0] start);
        logic [9:0] gap;
        logic [9:0] j;
        logic [9:0] h;
        gap = start;
        j = start + 10'd1;
        if (tbl_count > 0) tbl_count--;
        for (int n = 0; n < NSLOTS && tbl_keys[j] != 64'd0; n++) begin
            h = home_slot(tbl_keys[j]);
            if (10'(gap - h) < 10'(j - h)) begin
                tbl_keys[gap] = tbl_keys[j];
                tbl_vals[gap] = tbl_vals[j];
                gap = j;
            end
            j = j + 10'd1;
        end
        tbl_keys[gap] = 64'd0;
        tbl_vals[gap] = 32'd0;
    endfunction

    function automatic answer_t table_answer(input request_t r);
        answer_t a;
        logic [9:0] i;
        bit hit;
        a = '0;
        hit = 1'b0;
        if (r.key == 64'd0) begin
            a.status = ST_ZEROKEY;
            return a;
        end
        i = home_slot(r.key);
        for (int n = 0; n < NSLOTS; n++) begin
            if (tbl_keys[i] == 64'd0) break;
            if (tbl_keys[i] == r.key) begin
                hit = 1'b1;
                break;
            end
            i = i + 10'd1;
        end
        if (hit) begin
            a.found = 1'b1;
            a.value = tbl_vals[i];
            a.slot = i;
            a.status = ST_OK;
            if (r.cmd == CMD_ERASE) erase_slot(i);
        end else if (r.cmd == CMD_INSERT) begin
            if ((tbl_count + 1) * 4 >= LOAD_LIMIT) begin
                a.status = ST_FULL;
            end else begin
                i = home_slot(r.key);
                for (int n = 0; n < NSLOTS && tbl_keys[i] != 64'd0; n++) i = i + 10'd1;
                if (tbl_keys[i] != 64'd0) begin
                    a.status = ST_FULL;
                end else begin
                    tbl_keys[i] = r.key;
                    tbl_vals[i] = r.val;
                    tbl_count++;
                    a.value = r.val;
                    a.slot = i;
                    a.status = ST_OK;
                end
            end
        end else begin
            a.status = ST_NOTFOUND;
        end
        return a;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (keys_held.size() > 0 && r < 60)
            return keys_held[$urandom_range(0, keys_held.size() - 1)];
        if (r < 63) return 64'd0;
        if (r < 75) return 64'($urandom_range(1, 64));
        return rand_key();
    endfunction

    task automatic add_request(input cmd_t c, input logic [63:0] k, input logic [31:0] v);
        request_t r;
        r.cmd = c;
        r.key = k;
        r.val = v;
        pending_requests.push_back(r);
        if (c == CMD_INSERT && k != 64'd0) keys_held.push_back(k);
    endtask

    initial begin
        cmd_t c;
        int r;
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_keys[i] = '0;
            tbl_vals[i] = '0;
        end
        tbl_count = 0;
        add_request(CMD_LOOKUP, 64'd0, 32'hffffffff);
        add_request(CMD_INSERT, 64'd0, 32'h12345678);
        add_request(CMD_ERASE, 64'd0, 32'd0);
        add_request(CMD_OTHER, 64'd0, 32'd0);
        add_request(CMD_LOOKUP, 64'hffffffffffffffff, 32'd0);
        add_request(CMD_ERASE, 64'd5, 32'd0);
        add_request(CMD_INSERT, 64'hffffffffffffffff, 32'hffffffff);
        add_request(CMD_INSERT, 64'd1, 32'd0);
        add_request(CMD_INSERT, 64'd1, 32'haaaaaaaa);
        add_request(CMD_INSERT, 64'h8000000000000000, 32'h55555555);
        add_request(CMD_OTHER, 64'd1, 32'd0);
        add_request(CMD_LOOKUP, 64'hffffffffffffffff, 32'd0);
        for (int k = 2; k < 10; k++) add_request(CMD_INSERT, 64'(k), 32'(k * 7));
        add_request(CMD_ERASE, 64'd1, 32'd0);
        add_request(CMD_ERASE, 64'd1, 32'd0);
        add_request(CMD_LOOKUP, 64'd5, 32'd0);
        add_request(CMD_ERASE, 64'hffffffffffffffff, 32'd0);
        // Fill a good part of the table so that clusters form.
        for (int k = 0; k < 400; k++) add_request(CMD_INSERT, rand_key(), $urandom());
        add_request(CMD_INSERT, rand_key(), $urandom());
        add_request(CMD_INSERT, 64'd3, 32'd0);
        for (int k = 0; k < 100; k++) begin
            r = $urandom_range(0, 99);
            c = r < 45 ? CMD_ERASE : r < 75 ? CMD_LOOKUP : r < 97 ? CMD_INSERT : CMD_OTHER;
            add_request(c, pick_key(), $urandom());
        end
        for (int k = 0; k < 130; k++) begin
            r = $urandom_range(0, 99);
            c = r < 40 ? CMD_INSERT : r < 70 ? CMD_ERASE : r < 96 ? CMD_LOOKUP : CMD_OTHER;
            add_request(c, pick_key(), $urandom());
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_requests.size() == 0 && !s_axis_tvalid);
        stimulus_done = 1'b1;
    end

    always @(posedge aclk) begin
        request_t r;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_answers.push_back(table_answer(request_t'(s_axis_tdata[97:0])));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    r = pending_requests.pop_front();
                    s_axis_tdata <= {6'd0, r.val, r.key, r.cmd};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[44:0];
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected answer %h", $time, got);
                    errors++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.found !== want.found)
                        $display("%0t: found expected %0d actual %0d", $time, want.found,
                                 got.found);
                    if (got.value !== want.value)
                        $display("%0t: value expected %h actual %h", $time, want.value,
                                 got.value);
                    if (got.slot !== want.slot)
                        $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                                 got.slot);
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 got.status);
                    if (got !== want) errors++;
                end
            end
            rx_phase = (rx_phase + 1) % 400;
            if (rx_phase < 120) m_axis_tready <= 1'b1;
            else if (rx_phase < 260) m_axis_tready <= ($urandom_range(0, 3) != 0);
            else m_axis_tready <= ($urandom_range(0, 4) == 0);
        end
    end

    initial begin
        wait (stimulus_done);
        wait (expected_answers.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule
